[rtl/core/rdx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdx_pkg
// Shared types, character constants and the digit-to-ASCII map of the
// radix converter.
// ----------------------------------------------------------------------------
package rdx_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned BaseW    = 6;
  localparam int unsigned DigitW   = 6;
  localparam int unsigned OutCharW = 7;

  typedef logic [CharW-1:0]    char_t;
  typedef logic [BaseW-1:0]    base_t;
  typedef logic [DigitW-1:0]   digit_t;
  typedef logic [OutCharW-1:0] ochar_t;

  localparam char_t CharZero = 8'h30;
  localparam char_t CharNine = 8'h39;
  localparam char_t CharLowA = 8'h61;

  localparam base_t  BaseMin  = 6'd2;
  localparam base_t  BaseMax  = 6'd36;
  localparam digit_t DecRadix = 6'd10;

  function automatic ochar_t digit_ascii(digit_t d);
    if (d < DecRadix) begin
      return ochar_t'(CharZero) + ochar_t'(d);
    end
    return ochar_t'(CharLowA) + ochar_t'(d - DecRadix);
  endfunction

endpackage
`default_nettype wire

[rtl/core/rdx_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdx_in_if / rdx_out_if
// Valid/ready channels for incoming digit characters and emitted characters.
// ----------------------------------------------------------------------------
interface rdx_in_if;
  logic            valid;
  logic            ready;
  rdx_pkg::char_t  digit_char;
  rdx_pkg::base_t  in_base;
  rdx_pkg::base_t  out_base;
  logic            last_digit;

  modport source (output valid, output digit_char, output in_base, output out_base,
                  output last_digit, input ready);
  modport sink   (input valid, input digit_char, input in_base, input out_base,
                  input last_digit, output ready);
endinterface

interface rdx_out_if;
  logic            valid;
  logic            ready;
  rdx_pkg::ochar_t out_char;
  logic            last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface
`default_nettype wire

[rtl/core/rdx_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdx_div
// Restoring divider, one quotient bit per cycle, by a small divisor.
// ----------------------------------------------------------------------------
module rdx_div #(
  parameter int unsigned ValueWidth = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [ValueWidth-1:0] dividend_i,
  input  wire rdx_pkg::base_t        divisor_i,
  output logic      [ValueWidth-1:0] quo_o,
  output rdx_pkg::digit_t            rem_o,
  output logic                       done_o
);

  localparam int unsigned CntW = $clog2(ValueWidth);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [ValueWidth-1:0] quo_q, quo_d;
  rdx_pkg::digit_t       rem_q, rem_d;
  rdx_pkg::base_t        div_q, div_d;

  logic [rdx_pkg::DigitW:0] trial;
  logic [rdx_pkg::DigitW:0] diff;
  logic                     ge;

  assign trial = {rem_q, quo_q[ValueWidth-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(ValueWidth - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[ValueWidth-2:0], ge};
      rem_d = ge ? diff[rdx_pkg::DigitW-1:0] : trial[rdx_pkg::DigitW-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

[rtl/core/rdx_dstore.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdx_dstore
// Digit scratch memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rdx_dstore #(
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire rdx_pkg::digit_t          wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output rdx_pkg::digit_t               rdata_o
);

  rdx_pkg::digit_t mem_q [Depth];
  rdx_pkg::digit_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/core/radix_converter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radix_converter
// Horner accumulation of digit characters, then serial conversion of the
// value into lower-case ASCII digits of the output base.
// ----------------------------------------------------------------------------
// A digit without the last flag is taken with one VALUE_WIDTH x 6
// multiply-add into the accumulator. On the last digit the block stops
// taking input and converts the value: the shared bit-serial divider
// writes every output digit into the digit memory, and each digit is then
// read back (S_RD), loaded (S_LOAD) and presented (S_OUT), where it waits
// while the sink holds ready low. A zero value emits a single '0' in the
// cycle after the last digit. At most MAX_DIGITS least significant digits
// are emitted.
// ----------------------------------------------------------------------------
module radix_converter #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_DIGITS  = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rdx_in_if.sink    in_i,
  rdx_out_if.source out_o
);

  localparam int unsigned IdxW = $clog2(MAX_DIGITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [IdxW-1:0]        cnt_q, cnt_d;
  rdx_pkg::base_t         obase_q, obase_d;
  rdx_pkg::ochar_t        och_q, och_d;
  logic                   olast_q, olast_d;

  logic                   in_xfer;
  logic                   is_dec;
  logic [VALUE_WIDTH-1:0] dig_val;
  logic [VALUE_WIDTH-1:0] acc_mac;
  rdx_pkg::base_t         ob_clamp;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  rdx_pkg::base_t         div_divisor;
  logic [VALUE_WIDTH-1:0] div_quo;
  rdx_pkg::digit_t        div_rem;
  logic                   div_done;

  logic                   mem_we;
  logic                   mem_re;
  rdx_pkg::digit_t        mem_rdata;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  assign is_dec  = (in_i.digit_char >= rdx_pkg::CharZero) &&
                   (in_i.digit_char <= rdx_pkg::CharNine);
  assign dig_val = is_dec ? VALUE_WIDTH'(in_i.digit_char - rdx_pkg::CharZero)
                          : VALUE_WIDTH'(in_i.digit_char) + VALUE_WIDTH'(rdx_pkg::DecRadix)
                            - VALUE_WIDTH'(rdx_pkg::CharLowA);
  assign acc_mac = VALUE_WIDTH'(acc_q * VALUE_WIDTH'(in_i.in_base)) + dig_val;

  assign ob_clamp = (in_i.out_base < rdx_pkg::BaseMin) ? rdx_pkg::BaseMin :
                    (in_i.out_base > rdx_pkg::BaseMax) ? rdx_pkg::BaseMax :
                    in_i.out_base;

  assign div_dividend = (state_q == S_IDLE) ? acc_mac : div_quo;
  assign div_divisor  = (state_q == S_IDLE) ? ob_clamp : obase_q;

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    obase_d   = obase_q;
    och_d     = och_q;
    olast_d   = olast_q;
    div_start = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (!in_i.last_digit) begin
            acc_d = acc_mac;
          end else begin
            acc_d   = '0;
            obase_d = ob_clamp;
            cnt_d   = '0;
            if (acc_mac == '0) begin
              och_d   = rdx_pkg::ochar_t'(rdx_pkg::CharZero);
              olast_d = 1'b1;
              state_d = S_OUT;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          mem_we = 1'b1;
          if ((div_quo != '0) && (cnt_q != IdxW'(MAX_DIGITS - 1))) begin
            cnt_d     = cnt_q + IdxW'(1);
            div_start = 1'b1;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        och_d   = rdx_pkg::digit_ascii(mem_rdata);
        olast_d = (cnt_q == '0);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_o.ready) begin
          if (olast_q) begin
            state_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q - IdxW'(1);
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obase_q <= obase_d;
    och_q   <= och_d;
    olast_q <= olast_d;
  end

  rdx_div #(
    .ValueWidth (VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  rdx_dstore #(
    .Depth (MAX_DIGITS)
  ) u_dstore (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q),
    .wdata_i (div_rem),
    .re_i    (mem_re),
    .raddr_i (cnt_q),
    .rdata_o (mem_rdata)
  );

  assign out_o.valid     = (state_q == S_OUT);
  assign out_o.out_char  = och_q;
  assign out_o.last_char = olast_q;

`ifndef SYNTH
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the division phase");

  a_last_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.last_digit) |=> !in_i.ready)
    else $error("input taken while a number is being converted");

  a_last_char_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_char) |=> in_i.ready)
    else $error("not idle after the final character transfer");

  a_acc_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.last_digit) |=> (acc_q == '0))
    else $error("accumulator not cleared after the final digit");
`endif

endmodule
`default_nettype wire

[verif/radix_converter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_converter_tb
// Self-checking bench for the radix converter. Digit characters go in over
// the input channel; a behavioral Horner accumulator and divider predicts
// every emitted character, and each transfer on the output channel is
// compared with the oldest prediction. A short directed table is followed
// by mostly well-formed random numbers mixed with noise, under three idle
// patterns, one long output stall and a full drain after each pattern.
// ----------------------------------------------------------------------------
module radix_converter_tb;

  localparam int unsigned MaxDigits   = 32;
  localparam int unsigned DrainCycles = 1500;
  localparam int unsigned LongHold    = 400;

  typedef struct packed {
    rdx_pkg::char_t digit_char;
    rdx_pkg::base_t in_base;
    rdx_pkg::base_t out_base;
    logic           last_digit;
  } digit_item_t;

  typedef struct packed {
    rdx_pkg::ochar_t ch;
    logic            last;
  } out_digit_t;

  typedef struct packed {
    digit_item_t    item;
    logic           typed;
    rdx_pkg::char_t typed_ch;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;

  rdx_in_if  in_ch ();
  rdx_out_if out_ch ();

  radix_converter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  logic [31:0]  value_acc;
  out_digit_t   expected_chars[$];
  int unsigned  bad_count;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  bit           long_hold_req;

  // Typed rows are single-character numbers whose output is obvious.
  directed_row_t directed_rows [22] = '{
    '{'{"0", 6'd10, 6'd10, 1'b1}, 1'b1, "0"},
    '{'{"7", 6'd10, 6'd10, 1'b1}, 1'b1, "7"},
    '{'{"z", 6'd36, 6'd36, 1'b1}, 1'b1, "z"},
    '{'{"1", 6'd2,  6'd36, 1'b1}, 1'b1, "1"},
    '{'{"f", 6'd16, 6'd2,  1'b0}, 1'b0, "0"},
    '{'{"f", 6'd16, 6'd2,  1'b0}, 1'b0, "0"},
    '{'{"f", 6'd16, 6'd2,  1'b0}, 1'b0, "0"},
    '{'{"f", 6'd16, 6'd2,  1'b0}, 1'b0, "0"},
    '{'{"f", 6'd16, 6'd2,  1'b0}, 1'b0, "0"},
    '{'{"f", 6'd16, 6'd2,  1'b0}, 1'b0, "0"},
    '{'{"f", 6'd16, 6'd2,  1'b0}, 1'b0, "0"},
    '{'{"f", 6'd16, 6'd2,  1'b1}, 1'b0, "0"},
    '{'{"z", 6'd63, 6'd10, 1'b0}, 1'b0, "0"},
    '{'{"1", 6'd1,  6'd0,  1'b1}, 1'b0, "0"},
    '{'{"z", 6'd0,  6'd63, 1'b0}, 1'b0, "0"},
    '{'{"z", 6'd36, 6'd63, 1'b1}, 1'b0, "0"},
    '{'{8'h00, 6'd63, 6'd36, 1'b0}, 1'b0, "0"},
    '{'{8'hff, 6'd63, 6'd36, 1'b0}, 1'b0, "0"},
    '{'{8'hff, 6'd63, 6'd36, 1'b0}, 1'b0, "0"},
    '{'{8'hff, 6'd63, 6'd36, 1'b0}, 1'b0, "0"},
    '{'{8'h80, 6'd63, 6'd1,  1'b1}, 1'b0, "0"},
    '{'{"9", 6'd10, 6'd36, 1'b1}, 1'b1, "9"}
  };

  initial begin
    clk_i = 1'b0;
  end

  always #2 clk_i = ~clk_i;

  initial begin
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic rdx_pkg::char_t radix_char(int unsigned d);
    if (d < 10) begin
      return rdx_pkg::CharZero + rdx_pkg::char_t'(d);
    end
    return rdx_pkg::CharLowA + rdx_pkg::char_t'(d - 10);
  endfunction

  // Fold one digit into the accumulator; on the last digit, convert.
  function automatic void fold_digit(input digit_item_t it, ref out_digit_t outs[$]);
    logic [31:0]     dval;
    logic [31:0]     rem;
    int unsigned     obase;
    int unsigned     n;
    rdx_pkg::digit_t digs [MaxDigits];
    if (it.digit_char >= rdx_pkg::CharZero && it.digit_char <= rdx_pkg::CharNine) begin
      dval = 32'(it.digit_char - rdx_pkg::CharZero);
    end else begin
      dval = 32'(it.digit_char) + 32'd10 - 32'(rdx_pkg::CharLowA);
    end
    value_acc = value_acc * 32'(it.in_base) + dval;
    if (!it.last_digit) begin
      return;
    end
    obase = it.out_base;
    if (obase < rdx_pkg::BaseMin) begin
      obase = rdx_pkg::BaseMin;
    end
    if (obase > rdx_pkg::BaseMax) begin
      obase = rdx_pkg::BaseMax;
    end
    rem = value_acc;
    value_acc = '0;
    if (rem == 0) begin
      outs.push_back(out_digit_t'{rdx_pkg::ochar_t'(rdx_pkg::CharZero), 1'b1});
      return;
    end
    n = 0;
    while (rem != 0 && n < MaxDigits) begin
      digs[n] = rdx_pkg::digit_t'(rem % obase);
      rem = rem / obase;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      outs.push_back(out_digit_t'{rdx_pkg::ochar_t'(radix_char(digs[k])), k == 0});
    end
  endfunction

  task automatic offer_digit(input digit_item_t it, input bit typed,
                             input rdx_pkg::char_t typed_ch);
    out_digit_t fresh[$];
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid      <= 1'b1;
    in_ch.digit_char <= it.digit_char;
    in_ch.in_base    <= it.in_base;
    in_ch.out_base   <= it.out_base;
    in_ch.last_digit <= it.last_digit;
    do @(posedge clk_i); while (!in_ch.ready);
    fold_digit(it, fresh);
    if (typed) begin
      expected_chars.push_back(out_digit_t'{rdx_pkg::ochar_t'(typed_ch), 1'b1});
    end else begin
      foreach (fresh[i]) expected_chars.push_back(fresh[i]);
    end
  endtask

  task automatic send_random(input int unsigned count);
    digit_item_t it;
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        it.digit_char = rdx_pkg::char_t'($urandom_range(255));
        it.in_base    = rdx_pkg::base_t'($urandom_range(63));
        it.out_base   = rdx_pkg::base_t'($urandom_range(63));
        it.last_digit = ($urandom_range(3) == 0);
        offer_digit(it, 1'b0, rdx_pkg::CharZero);
        sent++;
      end else begin
        it.in_base  = rdx_pkg::base_t'($urandom_range(rdx_pkg::BaseMax, rdx_pkg::BaseMin));
        it.out_base = rdx_pkg::base_t'($urandom_range(rdx_pkg::BaseMax, rdx_pkg::BaseMin));
        len = ($urandom_range(9) == 0) ? $urandom_range(14, 8) : $urandom_range(5, 1);
        for (int k = 0; k < len; k++) begin
          it.digit_char = radix_char($urandom_range(it.in_base - 1));
          it.last_digit = (k == len - 1);
          offer_digit(it, 1'b0, rdx_pkg::CharZero);
          sent++;
        end
      end
    end
  endtask

  // Drop the offer, then hold until every predicted character has come.
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    out_digit_t exp_d;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("unexpected transfer: char %h last %b", out_ch.out_char, out_ch.last_char);
        end
      end else begin
        exp_d = expected_chars.pop_front();
        if (out_ch.out_char !== exp_d.ch || out_ch.last_char !== exp_d.last) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     exp_d.ch, exp_d.last, out_ch.out_char, out_ch.last_char);
          end
        end
      end
    end
  end

  initial begin
    bad_count        = 0;
    value_acc        = '0;
    long_hold_req    = 1'b0;
    send_idle_pct    = 11;
    recv_idle_pct    = 86;
    in_ch.valid      = 1'b0;
    in_ch.digit_char = '0;
    in_ch.in_base    = '0;
    in_ch.out_base   = '0;
    in_ch.last_digit = 1'b0;
    rst_ni           = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[r]) begin
      offer_digit(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].typed_ch);
    end
    send_random(46);
    wait_drained();

    send_idle_pct = 86;
    recv_idle_pct = 11;
    send_random(46);
    wait_drained();

    // Stall the output for a long stretch while input keeps coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b1;
    send_random(46);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (bad_count == 0 && expected_chars.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
